FILE: design/sacm_alu_pkg.sv
// Shared types for the signed add / compare / multiply ALU.
// Holds the operation codes used by the sequencer and the shared adder unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sacm_alu_pkg;

	// Operation codes carried in the low bits of the input transfer
	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_LESS = 2'd1,
		CMD_MUL  = 2'd2
	} cmd_t;

	localparam int unsigned CMD_W = 2;

endpackage

`default_nettype wire

FILE: design/sacm_alu_unit.sv
// Shared adder of the ALU: one carry-out adder reused for add, compare and
// each shift-add step of the multiply. Depends on sacm_alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacm_alu_unit
	import sacm_alu_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  cmd_t                  cmd,
	input  logic [DATA_WIDTH-1:0] op_a,
	input  logic [DATA_WIDTH-1:0] op_b,
	input  logic [DATA_WIDTH-1:0] acc,
	output logic [DATA_WIDTH-1:0] sum,
	output logic                  carry
);

	localparam logic [DATA_WIDTH-1:0] SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [DATA_WIDTH-1:0] x;
	logic [DATA_WIDTH-1:0] y;
	logic                  cin;

	// Select adder operands per operation
	always_comb begin
		unique case (cmd)
			CMD_ADD: begin
				x   = op_a;
				y   = op_b;
				cin = 1'b0;
			end
			CMD_LESS: begin
				// flip sign bits so signed order becomes unsigned order, then subtract
				x   = op_a ^ SIGN;
				y   = ~(op_b ^ SIGN);
				cin = 1'b1;
			end
			CMD_MUL: begin
				// add the shifted multiplicand when the current multiplier bit is set
				x   = acc;
				y   = op_b[0] ? op_a : '0;
				cin = 1'b0;
			end
			default: begin
				x   = '0;
				y   = '0;
				cin = 1'b0;
			end
		endcase
	end

	assign {carry, sum} = {1'b0, x} + {1'b0, y} + {{DATA_WIDTH{1'b0}}, cin};

endmodule

`default_nettype wire

FILE: design/signed_add_compare_multiply_alu_unit.sv
// Signed ALU top level: add, signed less-than, multiply (low word) on stream ports.
// An input transfer is captured, worked in the shared adder (multiply takes one
// shift-add step per operand bit), held in res_q and then moved to the output
// register. One item in work at a time: a new item is taken only once the last
// result has moved to the output register.
// Asynchronous active-low reset returns the sequencer to idle with no result held.
`timescale 1ns / 1ps
`default_nettype none

module signed_add_compare_multiply_alu_unit
	import sacm_alu_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned IN_TDATA_W  = ((CMD_W + 2 * DATA_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// cmd [1:0], operand_a, operand_b, zero fill to whole bytes
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// result, zero fill to whole bytes
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int unsigned CNT_W       = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;

	logic [CMD_W-1:0]             in_cmd;
	logic signed [DATA_WIDTH-1:0] in_operand_a;
	logic signed [DATA_WIDTH-1:0] in_operand_b;
	logic [DATA_WIDTH-1:0]        sum;
	logic                         carry;

	// Unpack the input transfer
	assign in_cmd       = s_axis_tdata[CMD_W-1:0];
	assign in_operand_a = s_axis_tdata[CMD_W +: DATA_WIDTH];
	assign in_operand_b = s_axis_tdata[CMD_W + DATA_WIDTH +: DATA_WIDTH];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

	sacm_alu_unit #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_unit (
		.cmd  (cmd_q),
		.op_a (a_q),
		.op_b (b_q),
		.acc  (acc_q),
		.sum  (sum),
		.carry(carry)
	);

	// Sequencer: capture, iterate the shared adder, hand off to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_ADD;
			a_q         <= '0;
			b_q         <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// drop the result once the downstream transfer completes, unless refilled
			if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q   <= cmd_t'(in_cmd);
						a_q     <= in_operand_a;
						b_q     <= in_operand_b;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					case (cmd_q)
						CMD_ADD: begin
							res_q   <= sum;
							state_q <= ST_DONE;
						end
						CMD_LESS: begin
							// no carry out means a < b after the sign flip
							res_q   <= DATA_WIDTH'(!carry);
							state_q <= ST_DONE;
						end
						CMD_MUL: begin
							// advance one multiplier bit per cycle
							acc_q <= sum;
							a_q   <= a_q << 1;
							b_q   <= b_q >> 1;
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == LAST_STEP) begin
								res_q   <= sum;
								state_q <= ST_DONE;
							end
						end
						default: begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					// hold until the output register is free or being drained
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: test/sacm_alu_result_checker.sv
// Result checker for the signed add / compare / multiply ALU.
// Watches both stream channels, predicts each result and compares in order.
// Depends on sacm_alu_pkg for the operation codes.
`timescale 1ns / 1ps

module sacm_alu_result_checker
	import sacm_alu_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned IN_W       = 72,
	parameter int unsigned OUT_W      = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	input  wire logic             s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [OUT_W-1:0] m_axis_tdata,
	output int unsigned           errors,
	output int unsigned           outstanding
);

	typedef struct {
		logic [CMD_W-1:0]      op;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		logic [DATA_WIDTH-1:0] result;
	} alu_item_t;

	// predicted results, oldest first
	alu_item_t awaited_results[$];

	// Work out the ALU result for one operation
	function automatic logic [DATA_WIDTH-1:0] compute_alu_result(
		logic [CMD_W-1:0] op, logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
		logic [DATA_WIDTH-1:0] r;
		case (cmd_t'(op))
			CMD_ADD:  r = a + b;
			CMD_LESS: r = DATA_WIDTH'(($signed(a) < $signed(b)) ? 1 : 0);
			// low word of a two's complement product does not depend on signedness
			CMD_MUL:  r = a * b;
			default:  r = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] result check: %s", $time, msg);
		errors++;
	endtask

	// Queue each accepted operation and check each accepted result
	always @(posedge clk) begin
		alu_item_t item;
		alu_item_t head;
		logic [DATA_WIDTH-1:0] got;
		if (!arst_n) begin
			errors = 0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				item.op     = s_axis_tdata[CMD_W-1:0];
				item.a      = s_axis_tdata[CMD_W +: DATA_WIDTH];
				item.b      = s_axis_tdata[CMD_W + DATA_WIDTH +: DATA_WIDTH];
				item.result = compute_alu_result(item.op, item.a, item.b);
				awaited_results.push_back(item);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[DATA_WIDTH-1:0];
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result %h with no operation pending", got));
				end else begin
					head = awaited_results.pop_front();
					if (got !== head.result)
						report_mismatch($sformatf("op %0d a %h b %h: result %h, predicted %h",
							head.op, head.a, head.b, got, head.result));
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: test/signed_add_compare_multiply_alu_unit_test.sv
// Testbench top for the signed add / compare / multiply ALU.
// Drives directed and random operations with random gaps and stalls; the
// result checker (sacm_alu_result_checker) predicts and compares. Needs sacm_alu_pkg.
`timescale 1ns / 1ps

module signed_add_compare_multiply_alu_unit_test;
	import sacm_alu_pkg::*;

	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned IN_W       = ((CMD_W + 2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int unsigned OUT_W      = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int          RANDOM_OPS = 1700;
	localparam int          HOLD_AT    = 600;
	localparam int          LONG_HOLD  = 400;
	localparam int          PAUSE_AT   = 1000;
	localparam int          DRAIN_WAIT = 40;
	localparam int          CYCLE_LIMIT = 500000;
	// code with no operation behind it
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// cmd [1:0], operand_a, operand_b, zero fill to whole bytes
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// result, zero fill to whole bytes
	logic [OUT_W-1:0] m_axis_tdata;

	int unsigned errors;
	int unsigned outstanding;
	int          cycles;
	bit          sender_eager;

	signed_add_compare_multiply_alu_unit #(
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	sacm_alu_result_checker #(
		.DATA_WIDTH(DATA_WIDTH),
		.IN_W(IN_W),
		.OUT_W(OUT_W)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Offer one operation after a random gap and hold it until the transfer
	task automatic send_op(logic [CMD_W-1:0] op, logic [DATA_WIDTH-1:0] a,
		logic [DATA_WIDTH-1:0] b);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= IN_W'({b, a, op});
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off until every predicted result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mix extremes, small values and full random words
	function automatic logic [DATA_WIDTH-1:0] pick_operand();
		logic [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0: v = MOST_NEG;
			1: v = MOST_POS;
			2: v = ALL_ONES;
			3: v = DATA_WIDTH'($urandom_range(0, 1));
			4, 5: begin
				v = DATA_WIDTH'($urandom_range(0, 300));
				if ($urandom_range(0, 1) == 1) v = -v;
			end
			default: v = DATA_WIDTH'({$urandom(), $urandom()});
		endcase
		return v;
	endfunction

	// Accept results after random stalls, with one long hold-off
	initial begin
		int stall;
		int taken;
		bit eager;
		taken = 0;
		eager = 1'b0;
		wait (arst_n);
		forever begin
			if (taken % 128 == 0) eager = ($urandom_range(0, 2) == 0);
			if (taken == HOLD_AT) stall = LONG_HOLD;
			else stall = eager ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
		end
	end

	// Stimulus and verdict
	initial begin
		logic [CMD_W-1:0]      op;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		int                    r;
		sender_eager = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrapping sums
		send_op(CMD_ADD, MOST_POS, DATA_WIDTH'(1));
		send_op(CMD_ADD, MOST_NEG, ALL_ONES);
		send_op(CMD_ADD, ALL_ONES, DATA_WIDTH'(1));
		send_op(CMD_ADD, '0, '0);
		send_op(CMD_ADD, ALL_ONES, ALL_ONES);
		// signed compare across the whole range
		send_op(CMD_LESS, MOST_NEG, MOST_POS);
		send_op(CMD_LESS, MOST_POS, MOST_NEG);
		send_op(CMD_LESS, MOST_NEG, MOST_NEG);
		send_op(CMD_LESS, ALL_ONES, '0);
		send_op(CMD_LESS, '0, ALL_ONES);
		send_op(CMD_LESS, MOST_NEG, DATA_WIDTH'(MOST_NEG + 1));
		// products that overflow, mix signs or involve the most negative value
		send_op(CMD_MUL, MOST_POS, MOST_POS);
		send_op(CMD_MUL, MOST_NEG, ALL_ONES);
		send_op(CMD_MUL, MOST_NEG, MOST_NEG);
		send_op(CMD_MUL, ALL_ONES, ALL_ONES);
		send_op(CMD_MUL, '0, MOST_NEG);
		send_op(CMD_MUL, DATA_WIDTH'(3), -DATA_WIDTH'(7));
		send_op(CMD_MUL, DATA_WIDTH'(32'h0001_0000), DATA_WIDTH'(32'h0001_0000));
		send_op(CMD_MUL, MOST_NEG, DATA_WIDTH'(2));
		// unused code yields zero
		send_op(CMD_SPARE, ALL_ONES, ALL_ONES);
		send_op(CMD_SPARE, DATA_WIDTH'($urandom()), DATA_WIDTH'($urandom()));
		wait_drained();

		// random operations with alternating traffic modes
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % 128 == 0) sender_eager = ($urandom_range(0, 2) == 0);
			if (i == PAUSE_AT) wait_drained();
			r = $urandom_range(0, 15);
			if (r == 0) op = CMD_SPARE;
			else if (r < 6) op = CMD_ADD;
			else if (r < 11) op = CMD_LESS;
			else op = CMD_MUL;
			a = pick_operand();
			b = pick_operand();
			// near-equal operands exercise the compare boundary
			if (op == CMD_LESS && $urandom_range(0, 2) == 0)
				b = a + DATA_WIDTH'($signed($urandom_range(0, 2)) - 1);
			send_op(op, a, b);
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
